// ----- rtl/square_wave_sound_channel_defines.svh -----
// Assertion macros for the square wave sound channel checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH

// Check post in the cycle after pre holds.
`define SQCH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sqch assertion failed");

// Check post in the same cycle as pre.
`define SQCH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sqch assertion failed");

`endif

// ----- rtl/sqch_pkg.sv -----
// Shared types, codes and helper functions for the square wave sound channel.
// No dependencies.
package sqch_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_FRAME = 2'd3;

  localparam logic [2:0] REG_SWEEP = 3'd0;
  localparam logic [2:0] REG_LEN   = 3'd1;
  localparam logic [2:0] REG_ENV   = 3'd2;
  localparam logic [2:0] REG_FLO   = 3'd3;
  localparam logic [2:0] REG_FHI   = 3'd4;
  localparam int unsigned NumRegs  = 5;

  localparam logic [2:0] STEP_SWEEP_A = 3'd2;
  localparam logic [2:0] STEP_SWEEP_B = 3'd6;
  localparam logic [2:0] STEP_ENV     = 3'd7;

  localparam logic CFG_HAS_SWEEP = 1'b0;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [2:0] seq_step;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample;
    logic       channel_on;
  } result_t;

  function automatic logic [11:0] sweep_calc(logic [10:0] shadow, logic [7:0] sweep_reg);
    logic [10:0] delta;
    delta = shadow >> sweep_reg[2:0];
    if (sweep_reg[3]) begin
      return {1'b0, shadow} - {1'b0, delta};
    end
    return {1'b0, shadow} + {1'b0, delta};
  endfunction

  function automatic logic [13:0] reload_value(logic [10:0] freq);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, freq};
    return {diff, 2'b00};
  endfunction

  function automatic logic duty_bit(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] pattern;
    case (sel)
      2'd0: pattern = 8'b1000_0000;
      2'd1: pattern = 8'b1000_0001;
      2'd2: pattern = 8'b1110_0001;
      2'd3: pattern = 8'b0111_1110;
      default: pattern = 8'b0000_0000;
    endcase
    return pattern[pos];
  endfunction

endpackage

// ----- rtl/sqch_core.sv -----
// Channel state and single-pass next-state logic for one transaction.
// Depends on sqch_pkg.
module sqch_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  sqch_pkg::item_t  item_i,
  input  logic             has_sweep_i,
  output sqch_pkg::result_t result_o
);

  logic [7:0]  ctrl_q [sqch_pkg::NumRegs];
  logic [7:0]  ctrl_d [sqch_pkg::NumRegs];
  logic [10:0] freq_q, freq_d;
  logic [10:0] shadow_q, shadow_d;
  logic [13:0] timer_q, timer_d;
  logic [2:0]  duty_pos_q, duty_pos_d;
  logic [1:0]  duty_sel_q, duty_sel_d;
  logic [6:0]  len_q, len_d;
  logic [3:0]  vol_q, vol_d;
  logic [3:0]  env_cnt_q, env_cnt_d;
  logic [3:0]  sweep_cnt_q, sweep_cnt_d;
  logic        ch_on_q, ch_on_d;
  logic        dac_q, dac_d;
  logic        env_on_q, env_on_d;
  logic        sweep_on_q, sweep_on_d;
  logic [3:0]  sample_q, sample_d;

  logic [7:0]  rd;
  logic [2:0]  period;
  logic [2:0]  shift;
  logic [2:0]  eperiod;
  logic [11:0] nf_trig, nf1, nf2;
  logic [13:0] tmr;
  logic [2:0]  pos;
  logic [3:0]  sc, ec, vol;

  assign period  = ctrl_q[sqch_pkg::REG_SWEEP][6:4];
  assign shift   = ctrl_q[sqch_pkg::REG_SWEEP][2:0];
  assign eperiod = ctrl_q[sqch_pkg::REG_ENV][2:0];

  always_comb begin
    for (int i = 0; i < sqch_pkg::NumRegs; i++) begin
      ctrl_d[i] = ctrl_q[i];
    end
    freq_d      = freq_q;
    shadow_d    = shadow_q;
    timer_d     = timer_q;
    duty_pos_d  = duty_pos_q;
    duty_sel_d  = duty_sel_q;
    len_d       = len_q;
    vol_d       = vol_q;
    env_cnt_d   = env_cnt_q;
    sweep_cnt_d = sweep_cnt_q;
    ch_on_d     = ch_on_q;
    dac_d       = dac_q;
    env_on_d    = env_on_q;
    sweep_on_d  = sweep_on_q;
    sample_d    = sample_q;
    rd          = 8'd0;
    nf_trig     = 12'd0;
    nf1         = 12'd0;
    nf2         = 12'd0;
    tmr         = timer_q;
    pos         = duty_pos_q;
    sc          = sweep_cnt_q;
    ec          = env_cnt_q;
    vol         = vol_q;

    case (item_i.func)
      sqch_pkg::FUNC_READ: begin
        case (item_i.reg_addr)
          sqch_pkg::REG_SWEEP: rd = has_sweep_i ? ctrl_q[sqch_pkg::REG_SWEEP] : 8'd0;
          sqch_pkg::REG_LEN:   rd = ctrl_q[sqch_pkg::REG_LEN];
          sqch_pkg::REG_ENV:   rd = ctrl_q[sqch_pkg::REG_ENV];
          sqch_pkg::REG_FLO:   rd = ctrl_q[sqch_pkg::REG_FLO];
          sqch_pkg::REG_FHI:   rd = ctrl_q[sqch_pkg::REG_FHI];
          default:             rd = 8'd0;
        endcase
      end
      sqch_pkg::FUNC_WRITE: begin
        case (item_i.reg_addr)
          sqch_pkg::REG_SWEEP: begin
            ctrl_d[sqch_pkg::REG_SWEEP] = item_i.write_data;
            sweep_cnt_d = {1'b0, item_i.write_data[6:4]};
          end
          sqch_pkg::REG_LEN: begin
            ctrl_d[sqch_pkg::REG_LEN] = item_i.write_data;
            len_d      = 7'd64 - {1'b0, item_i.write_data[5:0]};
            duty_sel_d = item_i.write_data[7:6];
          end
          sqch_pkg::REG_ENV: begin
            ctrl_d[sqch_pkg::REG_ENV] = item_i.write_data;
            vol_d     = item_i.write_data[7:4];
            env_cnt_d = {1'b0, item_i.write_data[2:0]};
            dac_d     = |item_i.write_data[7:3];
          end
          sqch_pkg::REG_FLO: begin
            ctrl_d[sqch_pkg::REG_FLO] = item_i.write_data;
            freq_d = {freq_q[10:8], item_i.write_data};
          end
          sqch_pkg::REG_FHI: begin
            ctrl_d[sqch_pkg::REG_FHI] = item_i.write_data;
            freq_d = {item_i.write_data[2:0], freq_q[7:0]};
            if (item_i.write_data[7]) begin
              ch_on_d = 1'b1;
              if (len_q == 7'd0) begin
                len_d = 7'd64;
              end
              timer_d     = sqch_pkg::reload_value(freq_d);
              vol_d       = ctrl_q[sqch_pkg::REG_ENV][7:4];
              env_cnt_d   = {1'b0, eperiod};
              env_on_d    = 1'b1;
              shadow_d    = freq_d;
              sweep_cnt_d = (period != 3'd0) ? {1'b0, period} : 4'd8;
              sweep_on_d  = (period != 3'd0) || (shift != 3'd0);
              nf_trig     = sqch_pkg::sweep_calc(freq_d, ctrl_q[sqch_pkg::REG_SWEEP]);
              if (has_sweep_i && shift != 3'd0 && nf_trig[11]) begin
                ch_on_d = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      sqch_pkg::FUNC_TICK: begin
        if (tmr != 14'd0) begin
          tmr = tmr - 14'd1;
        end
        if (tmr == 14'd0) begin
          pos = pos + 3'd1;
          tmr = sqch_pkg::reload_value(freq_q);
        end
        timer_d    = tmr;
        duty_pos_d = pos;
        sample_d   = (ch_on_q && dac_q && sqch_pkg::duty_bit(duty_sel_q, pos)) ? vol_q : 4'd0;
      end
      sqch_pkg::FUNC_FRAME: begin
        if (!item_i.seq_step[0] && ctrl_q[sqch_pkg::REG_FHI][6] && len_q != 7'd0) begin
          len_d = len_q - 7'd1;
          if (len_q == 7'd1) begin
            ch_on_d = 1'b0;
          end
        end
        if ((item_i.seq_step == sqch_pkg::STEP_SWEEP_A ||
             item_i.seq_step == sqch_pkg::STEP_SWEEP_B) && has_sweep_i) begin
          if (sc != 4'd0) begin
            sc = sc - 4'd1;
          end
          if (sc == 4'd0) begin
            sc = (period != 3'd0) ? {1'b0, period} : 4'd8;
            if (sweep_on_q && period != 3'd0) begin
              nf1 = sqch_pkg::sweep_calc(shadow_q, ctrl_q[sqch_pkg::REG_SWEEP]);
              if (nf1[11]) begin
                ch_on_d = 1'b0;
              end else if (shift != 3'd0) begin
                freq_d   = nf1[10:0];
                shadow_d = nf1[10:0];
                nf2 = sqch_pkg::sweep_calc(nf1[10:0], ctrl_q[sqch_pkg::REG_SWEEP]);
                if (nf2[11]) begin
                  ch_on_d = 1'b0;
                end
              end
            end
          end
          sweep_cnt_d = sc;
        end
        if (item_i.seq_step == sqch_pkg::STEP_ENV) begin
          if (ec != 4'd0) begin
            ec = ec - 4'd1;
          end
          if (ec == 4'd0) begin
            ec = (eperiod != 3'd0) ? {1'b0, eperiod} : 4'd8;
            if (eperiod != 3'd0 && env_on_q) begin
              if (ctrl_q[sqch_pkg::REG_ENV][3]) begin
                if (vol != 4'd15) begin
                  vol = vol + 4'd1;
                end
              end else if (vol != 4'd0) begin
                vol = vol - 4'd1;
              end
              if (vol == 4'd0 || vol == 4'd15) begin
                env_on_d = 1'b0;
              end
              vol_d = vol;
            end
          end
          env_cnt_d = ec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sqch_pkg::NumRegs; i++) begin
        ctrl_q[i] <= 8'd0;
      end
      freq_q      <= 11'd0;
      shadow_q    <= 11'd0;
      timer_q     <= 14'd0;
      duty_pos_q  <= 3'd0;
      duty_sel_q  <= 2'd0;
      len_q       <= 7'd0;
      vol_q       <= 4'd0;
      env_cnt_q   <= 4'd0;
      sweep_cnt_q <= 4'd0;
      ch_on_q     <= 1'b0;
      dac_q       <= 1'b0;
      env_on_q    <= 1'b0;
      sweep_on_q  <= 1'b0;
      sample_q    <= 4'd0;
    end else if (step_en_i) begin
      for (int i = 0; i < sqch_pkg::NumRegs; i++) begin
        ctrl_q[i] <= ctrl_d[i];
      end
      freq_q      <= freq_d;
      shadow_q    <= shadow_d;
      timer_q     <= timer_d;
      duty_pos_q  <= duty_pos_d;
      duty_sel_q  <= duty_sel_d;
      len_q       <= len_d;
      vol_q       <= vol_d;
      env_cnt_q   <= env_cnt_d;
      sweep_cnt_q <= sweep_cnt_d;
      ch_on_q     <= ch_on_d;
      dac_q       <= dac_d;
      env_on_q    <= env_on_d;
      sweep_on_q  <= sweep_on_d;
      sample_q    <= sample_d;
    end
  end

  assign result_o.read_data  = rd;
  assign result_o.sample     = sample_d;
  assign result_o.channel_on = ch_on_d;

endmodule

// ----- rtl/square_wave_sound_channel.sv -----
// Top level of the square wave sound channel: stream ports, APB port, stage registers.
// Depends on sqch_pkg and sqch_core.
//
//  channel   | dir | transaction when             | carries
//  s_axis    | in  | s_axis_tvalid & tready       | func, reg_addr, write_data, seq_step
//  m_axis    | out | m_axis_tvalid & tready       | read_data, sample, channel_on
//  apb       | in  | psel & penable & pwrite      | has_sweep at index 0
//
// One transaction per cycle sustained while m_axis_tready stays high; a result passes the input
// register and then the output register before its output transaction.
// The input register feeds the core, which updates all channel state whenever the stage advances.
// Reset clears all channel state and sets has_sweep.
// A stalled result holds the input stage; s_axis_tready drops only while both are full.
module square_wave_sound_channel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // reg_addr[2:0], write_data[10:3], seq_step[13:11]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // read_data[7:0], sample[11:8], channel_on[12]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sqch_pkg::item_t   in_q;
  logic              in_valid_q;
  sqch_pkg::result_t out_q;
  logic              out_valid_q;
  sqch_pkg::result_t core_res;
  logic              advance;
  logic              has_sweep_q;
  logic              cfg_sel;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.func       <= s_axis_tuser;
      in_q.reg_addr   <= s_axis_tdata[2:0];
      in_q.write_data <= s_axis_tdata[10:3];
      in_q.seq_step   <= s_axis_tdata[13:11];
    end
  end

  sqch_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (advance),
    .item_i      (in_q),
    .has_sweep_i (has_sweep_q),
    .result_o    (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.channel_on, out_q.sample, out_q.read_data};

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == sqch_pkg::CFG_HAS_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_sweep_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      has_sweep_q <= pwdata[0];
    end
  end

  assign prdata = cfg_sel ? {31'd0, has_sweep_q} : 32'd0;

endmodule

// ----- rtl/sqch_checker.sv -----
// Port-level checks for the square wave sound channel, bound to the top level.
// Depends on square_wave_sound_channel_defines.svh.
`include "square_wave_sound_channel_defines.svh"

module sqch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  `SQCH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  `SQCH_ASSERT_NOW(a_no_bubble, m_axis_tready, s_axis_tready)

  `SQCH_ASSERT_NEXT(a_latency, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready, m_axis_tvalid)

  `SQCH_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && paddr[2] == 1'b0 ##1 paddr[2] == 1'b0, prdata[0] == $past(pwdata[0], 2) && prdata[31:1] == 31'd0)

endmodule

bind square_wave_sound_channel sqch_checker u_sqch_checker (.*);

// ----- tb/square_wave_sound_channel_test.sv -----
// Self-checking square wave channel regression: directed table, then notes and raw items.
// Carries its own model of the channel; depends on sqch_pkg and square_wave_sound_channel.
module square_wave_sound_channel_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_UNUSED_LO = 3'd5;
  localparam logic [2:0] ADDR_UNUSED_HI = 3'd7;
  localparam logic [2:0] STEP_LEN_A     = 3'd0;
  localparam logic [2:0] SweepCfgAddr   = 3'(4 * sqch_pkg::CFG_HAS_SWEEP);
  localparam logic [7:0] DUTY_WAVES [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};
  localparam bit         SWEEP_PLAN [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
  localparam int unsigned PhaseItems    = 440;
  localparam int unsigned NumDirected   = 25;

  typedef struct {
    sqch_pkg::item_t   stim;
    logic              typed;
    sqch_pkg::result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // reg_addr[2:0], write_data[10:3], seq_step[13:11]
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // read_data[7:0], sample[11:8], channel_on[12]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // channel model state
  logic        has_sweep_m = 1'b1;
  logic [7:0]  regs_m [sqch_pkg::NumRegs] = '{default: 8'h00};
  logic [10:0] freq_m = '0;
  logic [10:0] shadow_m = '0;
  logic [13:0] timer_m = '0;
  logic [2:0]  duty_pos_m = '0;
  logic [1:0]  duty_sel_m = '0;
  logic [6:0]  len_m = '0;
  logic [3:0]  vol_m = '0;
  logic [3:0]  env_cnt_m = '0;
  logic [3:0]  sweep_cnt_m = '0;
  logic [3:0]  level_m = '0;
  logic        ch_on_m = 1'b0;
  logic        dac_on_m = 1'b0;
  logic        env_run_m = 1'b0;
  logic        sweep_on_m = 1'b0;

  sqch_pkg::result_t pulse_out_q [$];
  int unsigned error_count = 0;
  int unsigned items_offered = 0;
  int unsigned burst_left = 0;
  logic [2:0]  frame_pos = '0;
  bit          hold_off_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase = 0;

  dir_row_t dir_rows [NumDirected] = '{
    '{'{sqch_pkg::FUNC_READ,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_READ,  ADDR_UNUSED_HI,      8'hFF, sqch_pkg::STEP_ENV},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_TICK,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_FRAME, sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_SWEEP, 8'hFF, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_READ,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b1, '{8'hFF, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, ADDR_UNUSED_LO,      8'hFF, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_READ,  ADDR_UNUSED_LO,      8'h00, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_LEN,   8'hFF, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_ENV,   8'hF0, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_FLO,   8'hFF, STEP_LEN_A},
      1'b1, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_FHI,   8'hC7, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_TICK,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_TICK,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_FRAME, sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_ENV,   8'h07, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_FHI,   8'h87, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_TICK,  sqch_pkg::REG_SWEEP, 8'h00, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_ENV,   8'h19, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_FHI,   8'h87, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_FRAME, sqch_pkg::REG_SWEEP, 8'h00, sqch_pkg::STEP_ENV},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_SWEEP, 8'h11, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_WRITE, sqch_pkg::REG_FHI,   8'h87, STEP_LEN_A},
      1'b0, '{8'h00, 4'h0, 1'b0}},
    '{'{sqch_pkg::FUNC_FRAME, sqch_pkg::REG_SWEEP, 8'h00, sqch_pkg::STEP_SWEEP_A},
      1'b0, '{8'h00, 4'h0, 1'b0}}
  };

  square_wave_sound_channel i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5ns clk_i = ~clk_i;

  function automatic logic [13:0] period_reload();
    return 14'((2048 - int'(freq_m)) << 2);
  endfunction

  function automatic logic [11:0] sweep_next();
    logic [10:0] delta;
    logic [11:0] nf;
    delta = shadow_m >> regs_m[sqch_pkg::REG_SWEEP][2:0];
    nf = regs_m[sqch_pkg::REG_SWEEP][3] ? ({1'b0, shadow_m} - {1'b0, delta})
                                        : ({1'b0, shadow_m} + {1'b0, delta});
    if (nf > 12'd2047) ch_on_m = 1'b0;
    return nf;
  endfunction

  function automatic sqch_pkg::result_t pulse_step(input sqch_pkg::item_t it);
    logic [7:0]  rd;
    logic [7:0]  d;
    logic [2:0]  per;
    logic [2:0]  sh;
    logic [2:0]  eper;
    logic [11:0] nf;
    rd = 8'h00;
    d = it.write_data;
    per = regs_m[sqch_pkg::REG_SWEEP][6:4];
    sh = regs_m[sqch_pkg::REG_SWEEP][2:0];
    eper = regs_m[sqch_pkg::REG_ENV][2:0];
    case (it.func)
      sqch_pkg::FUNC_READ: begin
        if (it.reg_addr == sqch_pkg::REG_SWEEP) begin
          rd = has_sweep_m ? regs_m[sqch_pkg::REG_SWEEP] : 8'h00;
        end else if (it.reg_addr <= sqch_pkg::REG_FHI) begin
          rd = regs_m[it.reg_addr];
        end
      end
      sqch_pkg::FUNC_WRITE: begin
        if (it.reg_addr <= sqch_pkg::REG_FHI) regs_m[it.reg_addr] = d;
        case (it.reg_addr)
          sqch_pkg::REG_SWEEP: sweep_cnt_m = {1'b0, d[6:4]};
          sqch_pkg::REG_LEN: begin
            len_m = 7'(64 - d[5:0]);
            duty_sel_m = d[7:6];
          end
          sqch_pkg::REG_ENV: begin
            vol_m = d[7:4];
            env_cnt_m = {1'b0, d[2:0]};
            dac_on_m = |d[7:3];
          end
          sqch_pkg::REG_FLO: freq_m[7:0] = d;
          sqch_pkg::REG_FHI: begin
            freq_m[10:8] = d[2:0];
            if (d[7]) begin
              ch_on_m = 1'b1;
              if (len_m == 0) len_m = 7'd64;
              timer_m = period_reload();
              vol_m = regs_m[sqch_pkg::REG_ENV][7:4];
              env_cnt_m = {1'b0, eper};
              env_run_m = 1'b1;
              shadow_m = freq_m;
              sweep_cnt_m = (per != 0) ? {1'b0, per} : 4'd8;
              sweep_on_m = (per != 0) || (sh != 0);
              if (has_sweep_m && sh != 0) void'(sweep_next());
            end
          end
          default: ;
        endcase
      end
      sqch_pkg::FUNC_TICK: begin
        if (timer_m != 0) timer_m--;
        if (timer_m == 0) begin
          duty_pos_m++;
          timer_m = period_reload();
        end
        level_m = (ch_on_m && dac_on_m && DUTY_WAVES[duty_sel_m][duty_pos_m]) ? vol_m : 4'h0;
      end
      sqch_pkg::FUNC_FRAME: begin
        if (!it.seq_step[0] && regs_m[sqch_pkg::REG_FHI][6] && len_m != 0) begin
          len_m--;
          if (len_m == 0) ch_on_m = 1'b0;
        end
        if ((it.seq_step == sqch_pkg::STEP_SWEEP_A ||
             it.seq_step == sqch_pkg::STEP_SWEEP_B) && has_sweep_m) begin
          if (sweep_cnt_m != 0) sweep_cnt_m--;
          if (sweep_cnt_m == 0) begin
            sweep_cnt_m = (per != 0) ? {1'b0, per} : 4'd8;
            if (sweep_on_m && per != 0) begin
              nf = sweep_next();
              if (nf < 12'd2048 && sh != 0) begin
                freq_m = nf[10:0];
                shadow_m = nf[10:0];
                void'(sweep_next());
              end
            end
          end
        end
        if (it.seq_step == sqch_pkg::STEP_ENV) begin
          if (env_cnt_m != 0) env_cnt_m--;
          if (env_cnt_m == 0) begin
            env_cnt_m = (eper != 0) ? {1'b0, eper} : 4'd8;
            if (eper != 0 && env_run_m) begin
              if (regs_m[sqch_pkg::REG_ENV][3] && vol_m != 4'hF) begin
                vol_m++;
              end else if (!regs_m[sqch_pkg::REG_ENV][3] && vol_m != 4'h0) begin
                vol_m--;
              end
              if (vol_m == 4'h0 || vol_m == 4'hF) env_run_m = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return '{rd, level_m, ch_on_m};
  endfunction

  // Sender works in bursts; returns right after the transaction edge.
  task automatic drive_item(input sqch_pkg::item_t it);
    int unsigned gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.seq_step, it.write_data, it.reg_addr};
    s_axis_tuser <= it.func;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic offer(input sqch_pkg::item_t it);
    drive_item(it);
    pulse_out_q.push_back(pulse_step(it));
    items_offered++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pulse_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_update(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SweepCfgAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    has_sweep_m = value[0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, has_sweep_m}) begin
      $error("prdata: expected %0h, got %0h", {31'b0, has_sweep_m}, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed notes with random content; now and then one setup write is dropped.
  task automatic play_note();
    logic [7:0]  setup [sqch_pkg::NumRegs];
    logic [10:0] note_freq;
    int unsigned skip;
    int unsigned pick;
    setup[sqch_pkg::REG_SWEEP] = 8'($urandom);
    if ($urandom_range(0, 3) == 0) setup[sqch_pkg::REG_SWEEP][6:0] = '0;
    setup[sqch_pkg::REG_LEN] = 8'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      setup[sqch_pkg::REG_LEN][5:0] = 6'($urandom_range(56, 63));
    end
    setup[sqch_pkg::REG_ENV] = 8'($urandom);
    if ($urandom_range(0, 7) == 0) setup[sqch_pkg::REG_ENV][7:3] = '0;
    note_freq = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(2040, 2047)) : 11'($urandom);
    setup[sqch_pkg::REG_FLO] = note_freq[7:0];
    setup[sqch_pkg::REG_FHI] = {1'($urandom_range(0, 7) != 0), 1'($urandom), 3'($urandom),
                                note_freq[10:8]};
    skip = $urandom_range(0, 39);
    for (int r = 0; r < sqch_pkg::NumRegs; r++) begin
      if (r != skip) offer('{sqch_pkg::FUNC_WRITE, 3'(r), setup[r], 3'($urandom)});
    end
    repeat ($urandom_range(20, 60)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        offer('{sqch_pkg::FUNC_TICK, 3'($urandom), 8'($urandom), 3'($urandom)});
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) != 0) frame_pos++;
        else frame_pos = 3'($urandom);
        offer('{sqch_pkg::FUNC_FRAME, 3'($urandom), 8'($urandom), frame_pos});
      end else if (pick < 95) begin
        offer('{sqch_pkg::FUNC_READ, 3'($urandom), 8'($urandom), 3'($urandom)});
      end else begin
        offer('{sqch_pkg::FUNC_WRITE, 3'($urandom_range(0, 4)), 8'($urandom), 3'($urandom)});
      end
    end
  endtask

  // Receiver: changes its stall pattern now and then; a requested hold-off takes priority.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      rx_hold_left = 60;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    rx_phase++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_phase % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : out_check
    sqch_pkg::result_t got;
    sqch_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tdata[12]};
      if (pulse_out_q.size() == 0) begin
        $error("unexpected output transaction: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pulse_out_q.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
          error_count++;
        end
        if (got.sample !== want.sample) begin
          $error("sample: expected %0h, got %0h", want.sample, got.sample);
          error_count++;
        end
        if (got.channel_on !== want.channel_on) begin
          $error("channel_on: expected %0b, got %0b", want.channel_on, got.channel_on);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("square_wave_sound_channel regression: fail");
    $finish;
  end

  initial begin
    int unsigned phase_start;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      drive_item(dir_rows[i].stim);
      if (dir_rows[i].typed) begin
        void'(pulse_step(dir_rows[i].stim));
        pulse_out_q.push_back(dir_rows[i].want);
      end else begin
        pulse_out_q.push_back(pulse_step(dir_rows[i].stim));
      end
    end
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      cfg_update({31'($urandom), SWEEP_PLAN[p]});
      if (p % 2 == 1) hold_off_req = 1'b1;
      phase_start = items_offered;
      while (items_offered - phase_start < PhaseItems) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(3, 10)) begin
            offer('{2'($urandom), 3'($urandom), 8'($urandom), 3'($urandom)});
          end
        end else begin
          play_note();
        end
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("square_wave_sound_channel regression: pass");
    end else begin
      $display("square_wave_sound_channel regression: fail");
    end
    $finish;
  end

endmodule
